// File: hw/rtl/pmdc_pkg.sv
`timescale 1ns / 1ps
// Package for the pulsed motor drive controller.
// Command and motion codes, register map and drive constants; no dependencies.
package pmdc_pkg;

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_FORWARD  = 3'd1,
		CMD_BACKWARD = 3'd2,
		CMD_LEFT     = 3'd3,
		CMD_RIGHT    = 3'd4,
		CMD_STOP     = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		MOT_IDLE     = 3'd0,
		MOT_FORWARD  = 3'd1,
		MOT_BACKWARD = 3'd2,
		MOT_LEFT     = 3'd3,
		MOT_RIGHT    = 3'd4
	} motion_t;

	typedef enum logic [1:0] {
		COMP_NONE  = 2'd0,
		COMP_LEFT  = 2'd1,
		COMP_RIGHT = 2'd2
	} comp_t;

	typedef enum logic [1:0] {
		REG_MOVE_SPEED = 2'd0,
		REG_ROT_SPEED  = 2'd1,
		REG_TOGGLE     = 2'd2,
		REG_CALIB      = 2'd3
	} reg_idx_t;

	localparam logic [7:0] BACK_SLOWDOWN = 8'd40;
	localparam logic [7:0] SIDE_SLOWDOWN = 8'd80;

	localparam logic [7:0] MOVE_SPEED_RST = 8'd130;
	localparam logic [7:0] ROT_SPEED_RST  = 8'd130;
	localparam logic [7:0] TOGGLE_RST     = 8'd5;

	localparam logic [1:0] DIRS_FORWARD  = 2'b10;
	localparam logic [1:0] DIRS_BACKWARD = 2'b01;
	localparam logic [1:0] DIRS_LEFT     = 2'b11;
	localparam logic [1:0] DIRS_RIGHT    = 2'b00;

	function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
		sat_sub = (a > b) ? (a - b) : 8'd0;
	endfunction

endpackage

// File: hw/rtl/pulsed_motor_drive_controller_top.sv
`timescale 1ns / 1ps
// Pulsed motor drive controller: one input register stage, then the drive
// state itself serves as the result register. Depends on pmdc_pkg.
// Throughput: one item per cycle unless the output stalls; a single short
// combinational pass feeds the state registers. Reset: drive idle, duties,
// dirs, counters zero, lamp off.
module pulsed_motor_drive_controller_top #(
	parameter int BLINK_TICKS = 100,
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [2:0] command, [4:3] compensation, [5] wiggling
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [7:0] left_duty, [15:8] right_duty, [16] dir_one,
	                              // [17] dir_two, [20:18] motion, [21] lamp
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int BLINK_W = (BLINK_TICKS > 2) ? $clog2(BLINK_TICKS) : 1;
	localparam logic [BLINK_W-1:0] BLINK_LAST = BLINK_W'(BLINK_TICKS - 1);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	// configuration
	logic [7:0] move_speed_q;
	logic [7:0] rot_speed_q;
	logic [7:0] toggle_q;
	logic       calib_q;

	// input stage
	logic                valid_s1;
	pmdc_pkg::cmd_t      cmd_s1;
	logic [1:0]          comp_s1;
	logic                wiggle_s1;

	// drive state, also the result
	logic                out_valid_q;
	pmdc_pkg::motion_t   motion_q;
	logic [COUNT_WIDTH-1:0] tick_q;
	logic [BLINK_W-1:0]  blink_q;    // tick_q mod BLINK_TICKS, restarted when tick_q wraps
	logic                phase_q;
	logic                lamp_q;
	logic [7:0]          left_q;
	logic [7:0]          right_q;
	logic [1:0]          dirs_q;

	logic                advance;
	logic                cfg_wr;

	pmdc_pkg::motion_t   motion_nx;
	logic [COUNT_WIDTH-1:0] tick_nx;
	logic [BLINK_W-1:0]  blink_nx;
	logic                phase_nx;
	logic                lamp_nx;
	logic [7:0]          left_nx;
	logic [7:0]          right_nx;
	logic [1:0]          dirs_nx;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, ~lamp_q, motion_q, dirs_q[1], dirs_q[0], right_q, left_q};

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (pmdc_pkg::reg_idx_t'(paddr[3:2]))
			pmdc_pkg::REG_MOVE_SPEED: prdata = {24'd0, move_speed_q};
			pmdc_pkg::REG_ROT_SPEED:  prdata = {24'd0, rot_speed_q};
			pmdc_pkg::REG_TOGGLE:     prdata = {24'd0, toggle_q};
			pmdc_pkg::REG_CALIB:      prdata = {31'd0, calib_q};
			default:                  prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_speed_q <= pmdc_pkg::MOVE_SPEED_RST;
			rot_speed_q  <= pmdc_pkg::ROT_SPEED_RST;
			toggle_q     <= pmdc_pkg::TOGGLE_RST;
			calib_q      <= 1'b1;
		end else if (cfg_wr) begin
			unique case (pmdc_pkg::reg_idx_t'(paddr[3:2]))
				pmdc_pkg::REG_MOVE_SPEED: move_speed_q <= pwdata[7:0];
				pmdc_pkg::REG_ROT_SPEED:  rot_speed_q  <= pwdata[7:0];
				pmdc_pkg::REG_TOGGLE:     toggle_q     <= pwdata[7:0];
				pmdc_pkg::REG_CALIB:      calib_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1    <= pmdc_pkg::cmd_t'(s_tdata[2:0]);
			comp_s1   <= s_tdata[4:3];
			wiggle_s1 <= s_tdata[5];
		end
	end

	// next drive state for the item in the input register
	always_comb begin
		logic                   toggle;
		logic [7:0]             sp;
		logic [COUNT_WIDTH-1:0] tick_base;
		logic [BLINK_W-1:0]     blink_base;

		motion_nx = motion_q;
		tick_nx   = tick_q;
		blink_nx  = blink_q;
		phase_nx  = phase_q;
		lamp_nx   = lamp_q;
		left_nx   = left_q;
		right_nx  = right_q;
		dirs_nx   = dirs_q;

		toggle = (motion_q != pmdc_pkg::MOT_IDLE) && !wiggle_s1
			&& (tick_q > COUNT_WIDTH'(toggle_q));
		sp = (motion_q == pmdc_pkg::MOT_BACKWARD)
			? pmdc_pkg::sat_sub(move_speed_q, pmdc_pkg::BACK_SLOWDOWN) : move_speed_q;
		tick_base  = toggle ? '0 : tick_q;
		blink_base = toggle ? '0 : blink_q;

		case (cmd_s1)
			pmdc_pkg::CMD_TICK: begin
				if (toggle) begin
					phase_nx = !phase_q;
					if (phase_q) begin
						case (comp_s1)
							pmdc_pkg::COMP_NONE: begin
								left_nx  = sp;
								right_nx = sp;
							end
							pmdc_pkg::COMP_LEFT: begin
								left_nx  = pmdc_pkg::sat_sub(sp, pmdc_pkg::SIDE_SLOWDOWN);
								right_nx = sp;
							end
							pmdc_pkg::COMP_RIGHT: begin
								left_nx  = sp;
								right_nx = pmdc_pkg::sat_sub(sp, pmdc_pkg::SIDE_SLOWDOWN);
							end
							default: ;  // unknown side: duties hold
						endcase
					end else begin
						left_nx  = 8'd0;
						right_nx = 8'd0;
					end
				end else if (blink_q == '0 && calib_q) begin
					lamp_nx = !lamp_q;
				end
				tick_nx = tick_base + 1'b1;
				// counter wrap restarts the blink phase as well
				if (tick_base == COUNT_MAX || blink_base == BLINK_LAST) begin
					blink_nx = '0;
				end else begin
					blink_nx = blink_base + 1'b1;
				end
			end
			pmdc_pkg::CMD_FORWARD: begin
				left_nx   = move_speed_q;
				right_nx  = move_speed_q;
				dirs_nx   = pmdc_pkg::DIRS_FORWARD;
				motion_nx = pmdc_pkg::MOT_FORWARD;
				tick_nx   = '0;
				blink_nx  = '0;
			end
			pmdc_pkg::CMD_BACKWARD: begin
				left_nx   = pmdc_pkg::sat_sub(move_speed_q, pmdc_pkg::BACK_SLOWDOWN);
				right_nx  = pmdc_pkg::sat_sub(move_speed_q, pmdc_pkg::BACK_SLOWDOWN);
				dirs_nx   = pmdc_pkg::DIRS_BACKWARD;
				motion_nx = pmdc_pkg::MOT_BACKWARD;
				tick_nx   = '0;
				blink_nx  = '0;
			end
			pmdc_pkg::CMD_LEFT: begin
				left_nx   = rot_speed_q;
				right_nx  = rot_speed_q;
				dirs_nx   = pmdc_pkg::DIRS_LEFT;
				motion_nx = pmdc_pkg::MOT_LEFT;
				tick_nx   = '0;
				blink_nx  = '0;
			end
			pmdc_pkg::CMD_RIGHT: begin
				left_nx   = rot_speed_q;
				right_nx  = rot_speed_q;
				dirs_nx   = pmdc_pkg::DIRS_RIGHT;
				motion_nx = pmdc_pkg::MOT_RIGHT;
				tick_nx   = '0;
				blink_nx  = '0;
			end
			pmdc_pkg::CMD_STOP: begin
				left_nx   = 8'd0;
				right_nx  = 8'd0;
				motion_nx = pmdc_pkg::MOT_IDLE;
			end
			default: ;  // unknown command: state shown unchanged
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			motion_q    <= pmdc_pkg::MOT_IDLE;
			tick_q      <= '0;
			blink_q     <= '0;
			phase_q     <= 1'b0;
			lamp_q      <= 1'b1;
			left_q      <= 8'd0;
			right_q     <= 8'd0;
			dirs_q      <= 2'b00;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				motion_q    <= motion_nx;
				tick_q      <= tick_nx;
				blink_q     <= blink_nx;
				phase_q     <= phase_nx;
				lamp_q      <= lamp_nx;
				left_q      <= left_nx;
				right_q     <= right_nx;
				dirs_q      <= dirs_nx;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
